// File: rtl/core/lpc_pkg.sv
// Shared constants, codes and types for the LRU page cache.
`default_nettype none

package lpc_pkg;

  localparam int LPC_ENTRIES   = 128;
  localparam int LPC_DATA_BITS = 64;
  localparam int LPC_TAG_BITS  = 32;

  localparam logic [7:0] LPC_CAP_RESET = 8'd128;

  // Request kinds carried in the input tuser bit.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lpc_state_t;

endpackage

`default_nettype wire

// File: rtl/core/lpc_cell.sv
// One cache entry of the recency chain: holds a tag and payload, compares its tag.
`default_nettype none

module lpc_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 7,
  parameter int DATA_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             shift_en,
  input  wire logic [IDX_W-1:0]                 limit,
  input  wire logic                             prev_valid,
  input  wire logic [lpc_pkg::LPC_TAG_BITS-1:0] prev_tag,
  input  wire logic [DATA_BITS-1:0]             prev_data,
  input  wire logic [lpc_pkg::LPC_TAG_BITS-1:0] req_tag,
  output logic                                  valid,
  output logic [lpc_pkg::LPC_TAG_BITS-1:0]      tag,
  output logic [DATA_BITS-1:0]                  data,
  output logic                                  match
);
  import lpc_pkg::*;

  logic take;

  // Every cell at or below the limit position takes its neighbor's contents.
  assign take  = shift_en && (IDX_W'(INDEX) <= limit);
  assign match = valid && (tag == req_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag  <= prev_tag;
      data <= prev_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lru_page_cache.sv
// Top level of the fully associative LRU page cache built as a recency chain.
// A request passes the compare state, where the tag compare across the chain
// is registered, then the update state, where the chain shifts and the result
// is registered; a new request can be taken in that update state.
// Reset (rst, synchronous, active high) empties the cache, clears the entry
// count and sets the capacity to 128; no clearing pass is needed.
`default_nettype none

module lru_page_cache #(
  parameter int ENTRIES   = lpc_pkg::LPC_ENTRIES,
  parameter int DATA_BITS = lpc_pkg::LPC_DATA_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: capacity_in_use.
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // [31:0] page_number, [95:32] page_data
  input  wire logic [0:0]  s_axis_tuser,  // [0] action
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // [63:0] read_data, [71:64] entries_used
  output logic [0:0]       m_axis_tuser   // [0] hit
);
  import lpc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // The chain is ordered by recency: cell 0 holds the most recent entry and
  // the valid cells always form the prefix 0 .. occupancy-1. A hit at
  // position k moves cells 0..k-1 down by one and puts the hit entry in
  // cell 0. A put of a new page moves the whole valid prefix down and puts
  // the new page in cell 0; when the cache is full the last valid cell is
  // simply overwritten by its neighbor, which drops the least recent entry.

  lpc_state_t state;
  lpc_state_t state_next;

  logic                    in_fire;
  logic                    out_free;
  logic                    upd_fire;

  // Request registers.
  logic                    req_action;
  logic [LPC_TAG_BITS-1:0] req_tag;
  logic [DATA_BITS-1:0]    req_data;

  logic [7:0]              capacity;
  logic [CNT_W-1:0]        occ;
  logic [CNT_W-1:0]        occ_next;

  // Chain wiring.
  logic                    cell_valid [ENTRIES];
  logic [LPC_TAG_BITS-1:0] cell_tag   [ENTRIES];
  logic [DATA_BITS-1:0]    cell_data  [ENTRIES];
  logic                    prev_valid [ENTRIES];
  logic [LPC_TAG_BITS-1:0] prev_tag   [ENTRIES];
  logic [DATA_BITS-1:0]    prev_data  [ENTRIES];
  logic [ENTRIES-1:0]      match;
  logic [ENTRIES-1:0]      match_q;
  logic [ENTRIES-1:0]      valid_vec;

  // Update-cycle decode.
  logic                    any_hit;
  logic [IDX_W-1:0]        hit_idx;
  logic [DATA_BITS-1:0]    hit_payload;
  logic [CMP_W-1:0]        cap_eff;
  logic                    evict;
  logic                    shift_en;
  logic [IDX_W-1:0]        limit;
  logic [DATA_BITS-1:0]    head_data;

  // Output registers.
  logic                    out_valid;
  logic                    out_hit;
  logic [63:0]             out_rdata;
  logic [7:0]              out_used;

  // ---------------------------------------------------------------------
  // Handshakes and sequencing. A new request is taken while idle, or in
  // the update cycle of the previous one once the result register is free.
  // ---------------------------------------------------------------------
  assign out_free      = !out_valid || m_axis_tready;
  assign upd_fire      = (state == ST_UPD) && out_free;
  assign s_axis_tready = (state == ST_IDLE) || upd_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_next = in_fire ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= s_axis_tuser[0];
      req_tag    <= s_axis_tdata[LPC_TAG_BITS-1:0];
      req_data   <= s_axis_tdata[LPC_TAG_BITS +: DATA_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= LPC_CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // The row of cells. Cell 0 is fed with the entry being made most recent.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign prev_tag[i]   = req_tag;
      assign prev_data[i]  = head_data;
    end else begin : g_link
      assign prev_valid[i] = cell_valid[i-1];
      assign prev_tag[i]   = cell_tag[i-1];
      assign prev_data[i]  = cell_data[i-1];
    end

    lpc_cell #(
      .INDEX     (i),
      .IDX_W     (IDX_W),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (shift_en),
      .limit      (limit),
      .prev_valid (prev_valid[i]),
      .prev_tag   (prev_tag[i]),
      .prev_data  (prev_data[i]),
      .req_tag    (req_tag),
      .valid      (cell_valid[i]),
      .tag        (cell_tag[i]),
      .data       (cell_data[i]),
      .match      (match[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  // The compare result is registered in the compare cycle; the chain does not
  // change until the update cycle completes, so it stays current.
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      match_q <= match;
    end
  end

  // ---------------------------------------------------------------------
  // Update cycle: locate the hit, decide the shift range, update the count.
  // ---------------------------------------------------------------------
  always_comb begin
    hit_idx     = '0;
    hit_payload = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx     = hit_idx | IDX_W'(i);
        hit_payload = hit_payload | cell_data[i];
      end
    end
  end

  assign any_hit = |match_q;

  // A capacity of zero behaves as one, and anything above the chain length
  // behaves as the chain length.
  always_comb begin
    if (capacity == 8'd0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign evict = CMP_W'(occ) >= cap_eff;

  always_comb begin
    shift_en = 1'b0;
    limit    = '0;
    occ_next = occ;
    if (upd_fire) begin
      if (any_hit) begin
        shift_en = 1'b1;
        limit    = hit_idx;
      end else if (req_action == ACT_PUT) begin
        shift_en = 1'b1;
        if (evict) begin
          limit = IDX_W'(occ - CNT_W'(1));
        end else begin
          limit    = IDX_W'(occ);
          occ_next = occ + CNT_W'(1);
        end
      end
    end
  end

  // A get hit moves the stored payload to the head; a put writes new data.
  assign head_data = (req_action == ACT_GET) ? hit_payload : req_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit   <= any_hit;
      out_rdata <= (any_hit && (req_action == ACT_GET)) ? 64'(hit_payload) : 64'd0;
      out_used  <= 8'(occ_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_used, out_rdata};
  assign m_axis_tuser  = out_hit;

`ifndef SYNTHESIS
  // The valid cells always number exactly the entry count.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == occ)
    else $error("entry count differs from number of valid cells");

  // A page is held at most once, so at most one cell matches.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(match_q))
    else $error("more than one cell matched the requested page");

  // The entry count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(ENTRIES))
    else $error("entry count beyond chain length");

  // A get that misses leaves the chain untouched.
  a_get_miss_stable: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && !any_hit && (req_action == ACT_GET)) |=> $stable(valid_vec))
    else $error("a get miss changed the cache contents");
`endif

endmodule

`default_nettype wire

// File: sim/lru_page_cache_tb.sv
// Self-checking testbench for the LRU page cache: scoreboard, stream drivers and run control.
`timescale 1ns / 100ps

module lru_page_cache_tb;
  import lpc_pkg::*;

  localparam int ENT = LPC_ENTRIES;

  // One result of the cache as it appears on the result stream.
  typedef struct packed {
    logic        hit;
    logic [63:0] read_data;
    logic [7:0]  entries_used;
  } cache_result_t;

  // Scoreboard: keeps its own copy of the cache contents and recency order,
  // predicts the result of every accepted request and checks each result.
  class lru_scoreboard;
    logic [31:0]   tag_mem[ENT];
    logic [63:0]   data_mem[ENT];
    bit            valid_mem[ENT];
    int unsigned   age[ENT];
    int unsigned   used_count;
    logic [7:0]    capacity;
    cache_result_t expected_q[$];
    int unsigned   mismatches;
    int unsigned   requests_seen;
    int unsigned   hits_seen;
    int unsigned   evictions;
    int unsigned   peak_used;

    function new();
      foreach (valid_mem[i]) begin
        valid_mem[i] = 1'b0;
        age[i]       = 0;
        tag_mem[i]   = '0;
        data_mem[i]  = '0;
      end
      used_count    = 0;
      capacity      = LPC_CAP_RESET;
      mismatches    = 0;
      requests_seen = 0;
      hits_seen     = 0;
      evictions     = 0;
      peak_used     = 0;
    endfunction

    function void set_capacity(logic [7:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned limit_entries();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENT) c = ENT;
      return c;
    endfunction

    function int find_page(logic [31:0] page);
      for (int i = 0; i < ENT; i++)
        if (valid_mem[i] && tag_mem[i] == page) return i;
      return -1;
    endfunction

    // Move an entry to the front; the entries that were more recent age by one.
    function void make_newest(int idx);
      int unsigned r;
      r = age[idx];
      for (int i = 0; i < ENT; i++)
        if (valid_mem[i] && age[i] < r) age[i]++;
      age[idx] = 0;
    endfunction

    function void note_request(logic act, logic [31:0] page, logic [63:0] data);
      cache_result_t res;
      int            idx;
      int            victim;
      int            slot;
      idx = find_page(page);
      res.hit       = (idx >= 0);
      res.read_data = '0;
      requests_seen++;
      if (idx >= 0) hits_seen++;
      if (act == ACT_GET) begin
        if (idx >= 0) begin
          res.read_data = data_mem[idx];
          make_newest(idx);
        end
      end else if (idx >= 0) begin
        data_mem[idx] = data;
        make_newest(idx);
      end else begin
        if (used_count >= limit_entries()) begin
          victim = -1;
          for (int i = 0; i < ENT; i++)
            if (valid_mem[i] && (victim < 0 || age[i] > age[victim])) victim = i;
          if (victim >= 0) begin
            valid_mem[victim] = 1'b0;
            used_count--;
            evictions++;
          end
        end
        slot = -1;
        for (int i = 0; i < ENT; i++) begin
          if (valid_mem[i]) age[i]++;
          else if (slot < 0) slot = i;
        end
        if (slot >= 0) begin
          valid_mem[slot] = 1'b1;
          tag_mem[slot]   = page;
          data_mem[slot]  = data;
          age[slot]       = 0;
          used_count++;
        end
      end
      if (used_count > peak_used) peak_used = used_count;
      res.entries_used = used_count[7:0];
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic hit, logic [63:0] read_data, logic [7:0] entries_used);
      cache_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        exp_res = expected_q.pop_front();
        if (hit !== exp_res.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit, exp_res.hit));
        if (read_data !== exp_res.read_data)
          report_mismatch($sformatf("read_data %h, expected %h",
                                    read_data, exp_res.read_data));
        if (entries_used !== exp_res.entries_used)
          report_mismatch($sformatf("entries_used %0d, expected %0d",
                                    entries_used, exp_res.entries_used));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // Run control for the request driver and the result sink.
  bit          src_idle_on;
  bit          sink_idle_on;
  bit          stall_request;
  int unsigned capacity_writes;

  lru_scoreboard cache_sb;

  lru_page_cache u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the cache hangs; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("lru_page_cache_tb NOT OK");
    $finish;
  end

  // Offers one request starting at a falling edge, optionally after a few
  // idle cycles, and returns at the falling edge after it is accepted. The
  // valid line is left high so a following request can go out back to back.
  task automatic send_request(input logic act, input logic [31:0] page,
                              input logic [63:0] data);
    while (src_idle_on && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid   = 1'b1;
    s_axis_tdata    = {data, page};
    s_axis_tuser[0] = act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cache_sb.note_request(act, page, data);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every predicted result is back.
  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (cache_sb.pending() != 0) @(posedge clk);
  endtask

  // Capacity is only changed while the cache is idle. Every request gives a
  // result, so once every result is back the pipeline is empty.
  task automatic write_capacity(input logic [7:0] value);
    wait_for_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    cache_sb.set_capacity(value);
    capacity_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly pages from a small window so that hits and evictions are frequent,
  // with some fully random page numbers and the two extremes mixed in.
  function automatic logic [31:0] pick_page(logic [31:0] base, int unsigned window);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return 32'h0000_0000;
    if (roll < 6) return 32'hFFFF_FFFF;
    if (roll < 12) return $urandom;
    return base + $urandom_range(window - 1);
  endfunction

  function automatic logic [63:0] pick_data();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 64'h0;
    if (roll < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(input logic [7:0] cap, input int unsigned count,
                              input int unsigned window, input int unsigned put_pct);
    logic [31:0] base;
    logic        act;
    write_capacity(cap);
    base = $urandom;
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(99) < put_pct) ? ACT_PUT : ACT_GET;
      send_request(act, pick_page(base, window), pick_data());
    end
  endtask

  // Result sink: checks each accepted result at the rising edge and sets the
  // ready line for the next edge at the falling edge. A stall request from the
  // stimulus makes it hold ready low for a long, counted stretch.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        cache_sb.check_result(m_axis_tuser[0], m_axis_tdata[63:0], m_axis_tdata[71:64]);
      @(negedge clk);
      if (stall_request) begin
        hold_left     = 250;
        stall_request = 1'b0;
      end
      if (hold_left != 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (sink_idle_on && $urandom_range(99) < 31) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] fill_base;
    cache_sb        = new();
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    stall_request   = 1'b0;
    capacity_writes = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, starting from the reset capacity of 128.
    // A lookup in the empty cache misses.
    send_request(ACT_GET, 32'h0000_0000, 64'h0);
    // Extreme page numbers and payloads.
    send_request(ACT_PUT, 32'h0000_0000, 64'h0);
    send_request(ACT_PUT, 32'hFFFF_FFFF, '1);
    send_request(ACT_GET, 32'hFFFF_FFFF, 64'h0);
    // The payload of a lookup is ignored.
    send_request(ACT_GET, 32'h0000_0000, '1);
    // A put to a page that is present replaces its data.
    send_request(ACT_PUT, 32'h0000_0000, 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(ACT_GET, 32'h0000_0000, 64'h0);
    send_request(ACT_GET, 32'h0000_0001, 64'h0);
    send_request(ACT_PUT, 32'h0000_0001, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(ACT_GET, 32'hFFFF_FFFF, 64'h0);
    // Capacity lowered below the three entries held: each new page evicts
    // exactly one least recent entry and the count stays put.
    write_capacity(8'd2);
    send_request(ACT_PUT, 32'h0000_0002, 64'h1111_2222_3333_4444);
    send_request(ACT_GET, 32'h0000_0000, 64'h0);
    send_request(ACT_PUT, 32'h0000_0003, 64'h8000_0000_0000_0001);
    send_request(ACT_GET, 32'h0000_0001, 64'h0);
    send_request(ACT_PUT, 32'h0000_0003, 64'h0123_4567_89AB_CDEF);
    // A capacity of zero behaves as one.
    write_capacity(8'd0);
    send_request(ACT_PUT, 32'h0000_0004, 64'hDEAD_BEEF_0000_0004);
    send_request(ACT_GET, 32'h0000_0002, 64'h0);
    send_request(ACT_GET, 32'h0000_0004, 64'h0);
    // A capacity above the entry count behaves as the entry count.
    write_capacity(8'd255);
    send_request(ACT_PUT, 32'h0000_0005, 64'h5);
    send_request(ACT_PUT, 32'h0000_0006, 64'h6);
    send_request(ACT_GET, 32'h0000_0005, 64'h0);
    send_request(ACT_GET, 32'h7FFF_FFFF, 64'h0);

    // Random part: small capacities first, while few entries are held.
    random_phase(8'd4, 70, 8, 50);
    random_phase(8'd1, 40, 3, 50);
    random_phase(8'd0, 30, 3, 50);
    // A long stretch without any idling on either side.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_phase(8'd24, 90, 40, 55);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    // Fill the whole cache while the sink holds off, so the cache backs up
    // and stalls its request input, then keeps evicting at full occupancy.
    write_capacity(8'd255);
    fill_base     = $urandom;
    stall_request = 1'b1;
    for (int n = 0; n < 140; n++)
      send_request(ACT_PUT, fill_base + n, pick_data());
    for (int n = 0; n < 60; n++)
      send_request(($urandom_range(99) < 40) ? ACT_PUT : ACT_GET,
                   pick_page(fill_base, 160), pick_data());

    // Capacity far below the number held, then back to the maximum.
    random_phase(8'd3, 60, 200, 50);
    random_phase(8'd128, 60, 200, 50);

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Summary: %0d requests, %0d hits, %0d evictions, peak of %0d entries held.",
             cache_sb.requests_seen, cache_sb.hits_seen, cache_sb.evictions,
             cache_sb.peak_used);
    $display("Summary: %0d capacity writes (0, 1, small, 128 and 255) and one long sink stall.",
             capacity_writes);
    if (cache_sb.pending() != 0)
      cache_sb.report_mismatch($sformatf("%0d results never arrived", cache_sb.pending()));
    if (cache_sb.mismatches == 0) begin
      $display("lru_page_cache_tb OK");
    end else begin
      $display("lru_page_cache_tb NOT OK");
    end
    $finish;
  end

endmodule
